// ===== rtl/core/ptf_pkg.sv =====
// Shared types, constants and helper functions for the polar triangle fan generator.
package ptf_pkg;

   localparam int SINE_FRAC_BITS = 14;
   localparam int MAG_W          = SINE_FRAC_BITS + 1;
   localparam int LEN_W          = 12;
   localparam int DEG_W          = 9;
   localparam int IDX_W          = 7;
   localparam int COORD_W        = 16;
   localparam int WIDE_W         = COORD_W + 2;
   localparam int PROD_W         = LEN_W + MAG_W;
   localparam int OFF_W          = LEN_W + 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam int FULL_TURN      = 360;
   localparam int QUARTER_TURN   = 90;
   localparam int HALF_TURN      = 180;
   localparam int THREE_QUARTERS = 270;

   // table is Q1.14; rescale to Q1.SINE_FRAC_BITS
   localparam int SIN_UP  = (SINE_FRAC_BITS >= 14) ? SINE_FRAC_BITS - 14 : 0;
   localparam int SIN_DN  = (SINE_FRAC_BITS < 14) ? 14 - SINE_FRAC_BITS : 0;
   localparam int SIN_RND = (SIN_DN > 0) ? (1 << (SIN_DN - 1)) : 0;

   localparam logic [14:0] SINE_TBL [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   typedef struct packed {
      logic                      first_section;
      logic                      final_section;
      logic [LEN_W-1:0]          length;
      logic [DEG_W-1:0]          angle;
      logic [DEG_W-1:0]          rotation;
      logic signed [COORD_W-1:0] figure_x;
      logic signed [COORD_W-1:0] figure_y;
      logic signed [COORD_W-1:0] camera_x;
      logic signed [COORD_W-1:0] camera_y;
      logic [31:0]               fill_color;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert_a_x;
      logic signed [COORD_W-1:0] vert_a_y;
      logic signed [COORD_W-1:0] vert_b_x;
      logic signed [COORD_W-1:0] vert_b_y;
      logic signed [COORD_W-1:0] hub_x;
      logic signed [COORD_W-1:0] hub_y;
      logic [31:0]               tri_color;
      logic                      run_end;
   } rsp_type;

   // one finished vertex, passed from front to back
   typedef struct packed {
      logic                      first_section;
      logic                      final_section;
      logic signed [COORD_W-1:0] vx;
      logic signed [COORD_W-1:0] vy;
      logic signed [COORD_W-1:0] hx;
      logic signed [COORD_W-1:0] hy;
      logic [31:0]               color;
   } vtx_type;

   typedef struct packed {
      logic             neg;
      logic [IDX_W-1:0] idx;
   } fold_type;

   function automatic logic signed [COORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(32767);
      lo = -WIDE_W'(32768);
      if (v > hi) return COORD_W'(hi);
      if (v < lo) return COORD_W'(lo);
      return v[COORD_W-1:0];
   endfunction

   // wrap a sum below 3*360 into 0..359
   function automatic logic [DEG_W-1:0] wrap_deg(input logic [DEG_W:0] s);
      if (s >= (DEG_W+1)'(2 * FULL_TURN))
         return DEG_W'(s - (DEG_W+1)'(2 * FULL_TURN));
      if (s >= (DEG_W+1)'(FULL_TURN)) return DEG_W'(s - (DEG_W+1)'(FULL_TURN));
      return s[DEG_W-1:0];
   endfunction

   // quadrant fold onto the quarter-wave table
   function automatic fold_type fold(input logic [DEG_W-1:0] d);
      fold_type f;
      f.neg = 1'b0;
      if (d < DEG_W'(QUARTER_TURN)) begin
         f.idx = d[IDX_W-1:0];
      end else if (d < DEG_W'(HALF_TURN)) begin
         f.idx = IDX_W'(DEG_W'(HALF_TURN) - d);
      end else if (d < DEG_W'(THREE_QUARTERS)) begin
         f.idx = IDX_W'(d - DEG_W'(HALF_TURN));
         f.neg = 1'b1;
      end else begin
         f.idx = IDX_W'(DEG_W'(FULL_TURN) - d);
         f.neg = 1'b1;
      end
      return f;
   endfunction

   function automatic logic [MAG_W-1:0] sine_mag(input logic [IDX_W-1:0] idx);
      logic [31:0] w;
      w = ((32'(SINE_TBL[idx]) + 32'(SIN_RND)) >> SIN_DN) << SIN_UP;
      return w[MAG_W-1:0];
   endfunction

endpackage

// ===== rtl/core/polar_triangle_fan_generator.sv =====
// Top level of the polar triangle fan generator.
// Each request is one figure section (length, angle, rotation, center, camera
// offset, color). The front pipeline turns it into a vertex (angle wrap and
// quarter-wave sine lookup, length multiply, hub add with saturation) and
// places it in a four-entry queue; the back end turns queued vertices into
// fan triangles and, on a final section, the closing triangle, through a
// registered output. A request is taken every cycle while the queue has room;
// a non-first final section gives two triangles, fan then closing, which is
// what bounds sustained rate for such sections. A first section that is not
// final produces no response. A request reaches its first response through
// the s1 and s2 registers, the queue and the output register.
module polar_triangle_fan_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptf_pkg::rsp_type rsp_data
);
   import ptf_pkg::*;

   logic    push, q_full, pop, q_not_empty;
   vtx_type push_data, q_data;

   ptf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   ptf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   ptf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/core/ptf_front.sv =====
// Front pipeline: angle reduction, sine lookup, length multiply and vertex sum.
module ptf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptf_pkg::req_type req_data,
   output logic             push,
   output ptf_pkg::vtx_type push_data,
   input  logic             q_full
);
   import ptf_pkg::*;

   typedef struct packed {
      logic                      first_section;
      logic                      final_section;
      logic [LEN_W-1:0]          len;
      logic [MAG_W-1:0]          mag_x;
      logic                      neg_x;
      logic [MAG_W-1:0]          mag_y;
      logic                      neg_y;
      logic signed [COORD_W-1:0] hx;
      logic signed [COORD_W-1:0] hy;
      logic [31:0]               color;
   } s1_type;

   typedef struct packed {
      logic                      first_section;
      logic                      final_section;
      logic [OFF_W-1:0]          off_x;
      logic                      neg_x;
      logic [OFF_W-1:0]          off_y;
      logic                      neg_y;
      logic signed [COORD_W-1:0] hx;
      logic signed [COORD_W-1:0] hy;
      logic [31:0]               color;
   } s2_type;

   localparam logic [PROD_W-1:0] PROD_RND = PROD_W'(1) << (SINE_FRAC_BITS - 1);

   logic             s1_valid_ff, s2_valid_ff;
   s1_type           s1_ff, s1_in;
   s2_type           s2_ff, s2_in;
   logic             adv;
   logic [DEG_W-1:0] deg, deg_c;
   fold_type         fx, fy;
   logic [PROD_W-1:0] prod_x, prod_y;
   logic signed [WIDE_W-1:0] ox, oy;

   assign adv       = !s2_valid_ff || !q_full;
   assign req_stall = !adv;

   always_comb begin
      deg   = wrap_deg((DEG_W+1)'(req_data.angle) + (DEG_W+1)'(req_data.rotation));
      deg_c = wrap_deg((DEG_W+1)'(deg) + (DEG_W+1)'(QUARTER_TURN));
      fx    = fold(deg);
      fy    = fold(deg_c);
      s1_in.first_section = req_data.first_section;
      s1_in.final_section = req_data.final_section;
      s1_in.len   = req_data.length;
      s1_in.mag_x = sine_mag(fx.idx);
      s1_in.neg_x = fx.neg;
      s1_in.mag_y = sine_mag(fy.idx);
      s1_in.neg_y = fy.neg;
      s1_in.hx    = sat16(WIDE_W'(req_data.figure_x) + WIDE_W'(req_data.camera_x));
      s1_in.hy    = sat16(WIDE_W'(req_data.figure_y) + WIDE_W'(req_data.camera_y));
      s1_in.color = req_data.fill_color;
   end

   always_comb begin
      prod_x = PROD_W'(s1_ff.len) * PROD_W'(s1_ff.mag_x);
      prod_y = PROD_W'(s1_ff.len) * PROD_W'(s1_ff.mag_y);
      s2_in.first_section = s1_ff.first_section;
      s2_in.final_section = s1_ff.final_section;
      s2_in.off_x = OFF_W'((prod_x + PROD_RND) >> SINE_FRAC_BITS);
      s2_in.off_y = OFF_W'((prod_y + PROD_RND) >> SINE_FRAC_BITS);
      s2_in.neg_x = s1_ff.neg_x;
      s2_in.neg_y = s1_ff.neg_y;
      s2_in.hx    = s1_ff.hx;
      s2_in.hy    = s1_ff.hy;
      s2_in.color = s1_ff.color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   // signed offsets; y is hub minus the cosine term
   always_comb begin
      ox = signed'(WIDE_W'(s2_ff.off_x));
      oy = signed'(WIDE_W'(s2_ff.off_y));
      if (s2_ff.neg_x) ox = -ox;
      if (s2_ff.neg_y) oy = -oy;
      push_data.first_section = s2_ff.first_section;
      push_data.final_section = s2_ff.final_section;
      push_data.vx    = sat16(WIDE_W'(s2_ff.hx) + ox);
      push_data.vy    = sat16(WIDE_W'(s2_ff.hy) - oy);
      push_data.hx    = s2_ff.hx;
      push_data.hy    = s2_ff.hy;
      push_data.color = s2_ff.color;
   end

   assign push = s2_valid_ff && !q_full;

endmodule

// ===== rtl/core/ptf_queue.sv =====
// Short vertex queue between the front pipeline and the triangle emitter.
module ptf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptf_pkg::vtx_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output ptf_pkg::vtx_type pop_data
);
   import ptf_pkg::*;

   vtx_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (push && !pop)      count_ff <= count_ff + QCNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - QCNT_W'(1);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/core/ptf_back.sv =====
// Triangle emitter: keeps start and previous vertex, emits fan and closing triangles.
module ptf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  ptf_pkg::vtx_type q_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptf_pkg::rsp_type rsp_data
);
   import ptf_pkg::*;

   logic                      out_valid_ff;
   rsp_type                   out_ff;
   logic                      pend_ff;
   logic signed [COORD_W-1:0] pend_hx_ff, pend_hy_ff;
   logic [31:0]               pend_color_ff;
   logic signed [COORD_W-1:0] start_vx_ff, start_vy_ff, prev_vx_ff, prev_vy_ff;
   logic                      load;

   assign load      = !out_valid_ff || !rsp_stall;
   assign pop       = load && !pend_ff && q_not_empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         start_vx_ff  <= '0;
         start_vy_ff  <= '0;
         prev_vx_ff   <= '0;
         prev_vy_ff   <= '0;
      end else if (load) begin
         priority if (pend_ff) begin
            // closing triangle held back behind the fan triangle
            out_valid_ff     <= 1'b1;
            out_ff.vert_a_x  <= start_vx_ff;
            out_ff.vert_a_y  <= start_vy_ff;
            out_ff.vert_b_x  <= prev_vx_ff;
            out_ff.vert_b_y  <= prev_vy_ff;
            out_ff.hub_x     <= pend_hx_ff;
            out_ff.hub_y     <= pend_hy_ff;
            out_ff.tri_color <= pend_color_ff;
            out_ff.run_end   <= 1'b1;
            pend_ff          <= 1'b0;
         end else if (q_not_empty) begin
            prev_vx_ff    <= q_data.vx;
            prev_vy_ff    <= q_data.vy;
            pend_hx_ff    <= q_data.hx;
            pend_hy_ff    <= q_data.hy;
            pend_color_ff <= q_data.color;
            out_ff.hub_x     <= q_data.hx;
            out_ff.hub_y     <= q_data.hy;
            out_ff.tri_color <= q_data.color;
            out_ff.vert_a_x  <= q_data.vx;
            out_ff.vert_a_y  <= q_data.vy;
            if (q_data.first_section) begin
               start_vx_ff <= q_data.vx;
               start_vy_ff <= q_data.vy;
               // a one-section figure closes on itself
               out_valid_ff    <= q_data.final_section;
               out_ff.vert_b_x <= q_data.vx;
               out_ff.vert_b_y <= q_data.vy;
               out_ff.run_end  <= 1'b1;
            end else begin
               out_valid_ff    <= 1'b1;
               out_ff.vert_b_x <= prev_vx_ff;
               out_ff.vert_b_y <= prev_vy_ff;
               out_ff.run_end  <= !q_data.final_section;
               pend_ff         <= q_data.final_section;
            end
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== test/tb_polar_triangle_fan_generator.sv =====
// Testbench for the polar triangle fan generator: fan prediction, request and response drivers.
`timescale 1ns / 100ps

module tb_polar_triangle_fan_generator;
   import ptf_pkg::*;

   localparam int ITEM_COUNT   = 1650;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int GAP_PERCENT  = 6;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 100;
   localparam int QUIET_FROM   = 900;
   localparam int QUIET_TO     = 1250;
   localparam int MAX_PRINTED  = 50;

   localparam int DEG_QUARTER  = 90;
   localparam int DEG_HALF     = 180;
   localparam int DEG_3QUARTER = 270;
   localparam int DEG_FULL     = 360;

   // table holds Q1.14; rescale to the block's sine precision
   localparam int SINE_DOWN = (SINE_FRAC_BITS < 14) ? 14 - SINE_FRAC_BITS : 0;
   localparam int SINE_UP   = (SINE_FRAC_BITS > 14) ? SINE_FRAC_BITS - 14 : 0;
   localparam int SINE_HALF = (1 << SINE_DOWN) >> 1;

   localparam int SINE_Q14 [0:90] = '{
      0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
      5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
      8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };

   class fan_scoreboard;
      rsp_type expected_tris[$];
      int      start_x = 0;
      int      start_y = 0;
      int      prev_x = 0;
      int      prev_y = 0;
      int      errors = 0;
      int      tri_count = 0;

      function int clamp16(int v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      // round(len * sin(deg)), ties away from zero
      function int polar_offset(int len, int deg);
         int     idx;
         bit     neg;
         longint mag;
         longint prod;
         neg = 1'b0;
         if (deg < DEG_QUARTER) begin
            idx = deg;
         end else if (deg < DEG_HALF) begin
            idx = DEG_HALF - deg;
         end else if (deg < DEG_3QUARTER) begin
            idx = deg - DEG_HALF;
            neg = 1'b1;
         end else begin
            idx = DEG_FULL - deg;
            neg = 1'b1;
         end
         mag = ((longint'(SINE_Q14[idx]) + SINE_HALF) >> SINE_DOWN) << SINE_UP;
         prod = (longint'(len) * mag + (longint'(1) << (SINE_FRAC_BITS - 1)))
                >> SINE_FRAC_BITS;
         return neg ? -int'(prod) : int'(prod);
      endfunction

      function rsp_type make_tri(int ax, int ay, int bx, int by, int hx, int hy,
                                 logic [31:0] color, bit last);
         rsp_type t;
         t.vert_a_x  = COORD_W'(ax);
         t.vert_a_y  = COORD_W'(ay);
         t.vert_b_x  = COORD_W'(bx);
         t.vert_b_y  = COORD_W'(by);
         t.hub_x     = COORD_W'(hx);
         t.hub_y     = COORD_W'(hy);
         t.tri_color = color;
         t.run_end   = last;
         return t;
      endfunction

      function void note_request(req_type r);
         int hx, hy, deg, vx, vy;
         hx  = clamp16(int'($signed(r.figure_x)) + int'($signed(r.camera_x)));
         hy  = clamp16(int'($signed(r.figure_y)) + int'($signed(r.camera_y)));
         deg = (int'(r.angle) + int'(r.rotation)) % DEG_FULL;
         vx  = clamp16(hx + polar_offset(int'(r.length), deg));
         vy  = clamp16(hy - polar_offset(int'(r.length), (deg + DEG_QUARTER) % DEG_FULL));
         if (r.first_section) begin
            start_x = vx;
            start_y = vy;
         end else begin
            expected_tris.push_back(make_tri(vx, vy, prev_x, prev_y, hx, hy,
                                             r.fill_color, !r.final_section));
         end
         prev_x = vx;
         prev_y = vy;
         if (r.final_section)
            expected_tris.push_back(make_tri(start_x, start_y, prev_x, prev_y, hx, hy,
                                             r.fill_color, 1'b1));
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("mismatch at triangle %0d: %s", tri_count, msg);
      endtask

      task compare_field(string name, logic signed [32:0] got, logic signed [32:0] want);
         if (got !== want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_tris.size() == 0) begin
            report("triangle with none expected");
         end else begin
            want = expected_tris.pop_front();
            compare_field("vert_a_x", got.vert_a_x, want.vert_a_x);
            compare_field("vert_a_y", got.vert_a_y, want.vert_a_y);
            compare_field("vert_b_x", got.vert_b_x, want.vert_b_x);
            compare_field("vert_b_y", got.vert_b_y, want.vert_b_y);
            compare_field("hub_x", got.hub_x, want.hub_x);
            compare_field("hub_y", got.hub_y, want.hub_y);
            compare_field("tri_color", got.tri_color, want.tri_color);
            compare_field("run_end", got.run_end, want.run_end);
         end
         tri_count++;
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   fan_scoreboard sb;
   int sent = 0;
   int cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit no_gaps = 1'b0;

   polar_triangle_fan_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   // receiver: random stalls, one long hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && sent >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(99) < GAP_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d triangles outstanding",
                  cycles, sb.expected_tris.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type section(bit is_first, bit is_last, int len, int ang, int rot,
                                       int fx, int fy, int cx, int cy, logic [31:0] color);
      req_type r;
      r.first_section = is_first;
      r.final_section = is_last;
      r.length        = LEN_W'(len);
      r.angle         = DEG_W'(ang);
      r.rotation      = DEG_W'(rot);
      r.figure_x      = COORD_W'(fx);
      r.figure_y      = COORD_W'(fy);
      r.camera_x      = COORD_W'(cx);
      r.camera_y      = COORD_W'(cy);
      r.fill_color    = color;
      return r;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(9))
         0: return 32767;
         1: return -32768;
         2, 3: return int'($urandom_range(65535)) - 32768;
         default: return int'($urandom_range(8191)) - 4096;
      endcase
   endfunction

   function automatic int rand_angle();
      if ($urandom_range(9) == 0) return $urandom_range(511);
      return $urandom_range(359);
   endfunction

   function automatic int rand_length();
      case ($urandom_range(9))
         0: return 0;
         1: return 4095;
         default: return $urandom_range(4095);
      endcase
   endfunction

   task automatic send_request(input req_type r);
      no_gaps = (sent >= QUIET_FROM) && (sent < QUIET_TO);
      if (!no_gaps) begin
         while ($urandom_range(99) < GAP_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // mostly well-formed figures; a few miss their first or final section, or carry random flags
   task automatic random_figure();
      int      count;
      int      flaw;
      req_type r;
      count = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
      flaw  = $urandom_range(99);
      r = section(1'b0, 1'b0, 0, 0, rand_angle(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), $urandom);
      for (int i = 0; i < count; i++) begin
         r.first_section = (i == 0);
         r.final_section = (i == count - 1);
         if (flaw < 5) begin
            if (i == 0) r.first_section = 1'b0;
         end else if (flaw < 10) begin
            if (i == count - 1) r.final_section = 1'b0;
         end else if (flaw < 14) begin
            {r.first_section, r.final_section} = 2'($urandom_range(3));
         end
         r.length = LEN_W'(rand_length());
         r.angle  = DEG_W'(rand_angle());
         if ($urandom_range(19) == 0) r.fill_color = $urandom;
         send_request(r);
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sections with no opening one use the zero vertices left by reset
      send_request(section(0, 0, 4095, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
      send_request(section(0, 1, 100, 90, 0, 16, 16, 0, 0, 32'hFFFF_FFFF));
      // single-section figures, hub clamped at both ends
      send_request(section(1, 1, 4095, 45, 0, 32767, 32767, 32767, 32767, 32'h1234_5678));
      send_request(section(1, 1, 4095, 225, 0, -32768, -32768, -32768, -32768,
                           32'h8765_4321));
      // a full turn in quadrant steps; the opening section gives nothing
      send_request(section(1, 0, 800, 0, 0, 100, -100, 5, -5, 32'hAAAA_5555));
      send_request(section(0, 0, 800, 90, 0, 100, -100, 5, -5, 32'hAAAA_5555));
      send_request(section(0, 0, 800, 180, 0, 100, -100, 5, -5, 32'hAAAA_5555));
      send_request(section(0, 0, 800, 270, 0, 100, -100, 5, -5, 32'hAAAA_5555));
      send_request(section(0, 0, 800, 359, 0, 100, -100, 5, -5, 32'hAAAA_5555));
      send_request(section(0, 1, 0, 300, 200, 100, -100, 5, -5, 32'h5555_AAAA));
      // angle plus rotation well past a full turn
      send_request(section(1, 0, 2000, 511, 511, -500, 700, 33, -44, 32'h0F0F_0F0F));
      send_request(section(0, 1, 2000, 359, 359, -500, 700, 33, -44, 32'hF0F0_F0F0));
      // an open figure restarted by a new first section
      send_request(section(1, 0, 1234, 10, 20, 0, 0, 160, 160, 32'h0102_0304));
      send_request(section(0, 0, 1234, 130, 20, 0, 0, 160, 160, 32'h0102_0304));
      send_request(section(1, 0, 3000, 200, 100, 0, 0, 160, 160, 32'h0506_0708));
      send_request(section(0, 1, 3000, 310, 100, 0, 0, 160, 160, 32'h0506_0708));
      // vertices clamp on every edge
      send_request(section(1, 0, 4095, 90, 0, 32000, -32000, 0, 0, 32'hDEAD_BEEF));
      send_request(section(0, 0, 4095, 0, 0, 32000, -32000, 0, 0, 32'hDEAD_BEEF));
      send_request(section(0, 0, 4095, 270, 0, -32000, 32000, 0, 0, 32'hCAFE_F00D));
      send_request(section(0, 1, 4095, 180, 0, -32000, 32000, 0, 0, 32'hCAFE_F00D));

      while (sent < ITEM_COUNT) begin
         if ($urandom_range(99) < 5)
            send_request(req_type'({$urandom, $urandom, $urandom, $urandom}));
         else
            random_figure();
      end
      req_valid <= 1'b0;

      while (sb.expected_tris.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
